FILE: rtl/core/llp_pkg.sv
// ----------------------------------------------------------------------------
// llp_pkg
// request and status codes shared by the list pool manager modules
// ----------------------------------------------------------------------------
package llp_pkg;

    localparam logic [3:0] OP_PUSH_FRONT = 4'd0;
    localparam logic [3:0] OP_PUSH_BACK  = 4'd1;
    localparam logic [3:0] OP_POP_FRONT  = 4'd2;
    localparam logic [3:0] OP_POP_BACK   = 4'd3;
    localparam logic [3:0] OP_READ_AT    = 4'd4;
    localparam logic [3:0] OP_WRITE_AT   = 4'd5;
    localparam logic [3:0] OP_INSERT     = 4'd6;
    localparam logic [3:0] OP_ERASE      = 4'd7;
    localparam logic [3:0] OP_CLEAR      = 4'd8;
    localparam logic [3:0] OP_BAD        = 4'd15;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

endpackage

FILE: rtl/core/llp_fifo.sv
// ----------------------------------------------------------------------------
// llp_fifo
// two-entry register queue with push/full and pop/empty sides
// ----------------------------------------------------------------------------
module llp_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

FILE: rtl/core/llp_front.sv
// ----------------------------------------------------------------------------
// llp_front
// request intake: classifies the mode and queues requests for the engine
// ----------------------------------------------------------------------------
module llp_front #(
    parameter int VALUE_BITS = 32,
    parameter int PW         = 7
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [3:0]            i_mode,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic [PW-1:0]         i_position,
    input  logic                  i_take,
    output logic                  o_avail,
    output logic [3:0]            o_op,
    output logic [VALUE_BITS-1:0] o_value,
    output logic [PW-1:0]         o_pos
);
    import llp_pkg::*;

    localparam int QW = 4 + VALUE_BITS + PW;

    logic [3:0]    w_op;
    logic [QW-1:0] w_qout;
    logic          w_empty;

    // unknown modes collapse onto one code
    always_comb begin
        case (i_mode)
            OP_PUSH_FRONT, OP_PUSH_BACK, OP_POP_FRONT, OP_POP_BACK,
            OP_READ_AT, OP_WRITE_AT, OP_INSERT, OP_ERASE, OP_CLEAR: w_op = i_mode;
            default: w_op = OP_BAD;
        endcase
    end

    llp_fifo #(.WIDTH(QW)) u_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_data  ({w_op, i_value, i_position}),
        .i_pop   (i_take),
        .o_empty (w_empty),
        .o_data  (w_qout)
    );

    assign o_avail = !w_empty;
    assign o_op    = w_qout[QW-1 -: 4];
    assign o_value = w_qout[PW +: VALUE_BITS];
    assign o_pos   = w_qout[PW-1:0];

endmodule

FILE: rtl/core/llp_back.sv
// ----------------------------------------------------------------------------
// llp_back
// list engine: link, value and free-stack memories driven by a sequencer
// ----------------------------------------------------------------------------
module llp_back #(
    parameter int POOL_NODES = 64,
    parameter int VALUE_BITS = 32,
    parameter int PW         = 7
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_avail,
    output logic                  o_take,
    input  logic [3:0]            i_op,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic [PW-1:0]         i_pos,
    input  logic                  i_out_full,
    output logic                  o_res_push,
    output logic [1:0]            o_status,
    output logic [VALUE_BITS-1:0] o_read_value,
    output logic [PW-1:0]         o_node_handle,
    output logic [VALUE_BITS-1:0] o_front_value,
    output logic [VALUE_BITS-1:0] o_back_value,
    output logic [PW-1:0]         o_element_count
);
    import llp_pkg::*;

    localparam int LW = $clog2(POOL_NODES + 2);
    localparam int NW = $clog2(POOL_NODES);
    localparam logic [LW-1:0] TAIL   = LW'(POOL_NODES);
    localparam logic [LW-1:0] HEAD   = LW'(POOL_NODES + 1);
    localparam logic [PW-1:0] POOL_C = PW'(POOL_NODES);
    localparam logic [NW-1:0] LAST_N = NW'(POOL_NODES - 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_L0   = 4'd1;
    localparam logic [3:0] S_L1   = 4'd2;
    localparam logic [3:0] S_L2   = 4'd3;
    localparam logic [3:0] S_U0   = 4'd4;
    localparam logic [3:0] S_U1   = 4'd5;
    localparam logic [3:0] S_WALK = 4'd6;
    localparam logic [3:0] S_WAIT = 4'd7;
    localparam logic [3:0] S_ACC  = 4'd8;
    localparam logic [3:0] S_RDV  = 4'd9;
    localparam logic [3:0] S_FIN  = 4'd10;
    localparam logic [3:0] S_F1   = 4'd11;
    localparam logic [3:0] S_F2   = 4'd12;
    localparam logic [3:0] S_DONE = 4'd13;

    logic [LW-1:0]         m_nxt [POOL_NODES];
    logic [LW-1:0]         m_prv [POOL_NODES];
    logic [VALUE_BITS-1:0] m_val [POOL_NODES];
    logic [NW-1:0]         m_fs  [POOL_NODES];

    logic [LW-1:0]         r_nxt_rd, r_prv_rd;
    logic [VALUE_BITS-1:0] r_val_rd;
    logic [NW-1:0]         r_fs_rd;

    logic [3:0]            r_state;
    logic [3:0]            r_op;
    logic [VALUE_BITS-1:0] r_val;
    logic [PW-1:0]         r_pos;
    logic [LW-1:0]         r_head_next, r_tail_prev;
    logic [POOL_NODES-1:0] r_live;
    logic [PW-1:0]         r_top, r_min_top, r_count, r_i;
    logic [LW-1:0]         r_tgt, r_cur, r_p;
    logic [NW-1:0]         r_n;
    logic                  r_fs_init;
    logic [NW-1:0]         r_fs_val;
    logic [1:0]            r_status;
    logic [VALUE_BITS-1:0] r_rd, r_fr, r_bk;
    logic [PW-1:0]         r_handle;

    logic                  nxt_we, prv_we, val_we, fs_we;
    logic [NW-1:0]         nxt_wa, prv_wa, val_wa, fs_wa;
    logic [LW-1:0]         nxt_wd, prv_wd;
    logic [VALUE_BITS-1:0] val_wd;
    logic [NW-1:0]         fs_wd;
    logic [NW-1:0]         nxt_ra, prv_ra, val_ra, fs_ra;

    logic                  w_start;
    logic [PW-1:0]         w_top_m1;
    logic [NW-1:0]         w_new_n;
    logic [LW-1:0]         w_new_p;
    logic                  w_pos_live;

    assign w_start    = (r_state == S_IDLE) && i_avail && !i_out_full;
    assign o_take     = w_start;
    assign w_top_m1   = r_top - PW'(1);
    assign w_new_n    = r_fs_init ? r_fs_val : r_fs_rd;
    assign w_new_p    = (r_tgt == TAIL) ? r_tail_prev : r_prv_rd;
    assign w_pos_live = (i_pos < POOL_C) && r_live[i_pos[NW-1:0]];

    // memory port control
    always_comb begin
        nxt_we = 1'b0; nxt_wa = r_n; nxt_wd = r_tgt;
        prv_we = 1'b0; prv_wa = r_n; prv_wd = w_new_p;
        val_we = 1'b0; val_wa = w_new_n; val_wd = r_val;
        fs_we  = 1'b0; fs_wa = r_top[NW-1:0]; fs_wd = r_tgt[NW-1:0];
        nxt_ra = r_tgt[NW-1:0];
        prv_ra = r_tgt[NW-1:0];
        val_ra = r_cur[NW-1:0];
        fs_ra  = w_top_m1[NW-1:0];
        case (r_state)
            S_L1: begin
                nxt_we = 1'b1; nxt_wa = w_new_n; nxt_wd = r_tgt;
                prv_we = 1'b1; prv_wa = w_new_n; prv_wd = w_new_p;
                val_we = 1'b1;
            end
            S_L2: begin
                nxt_we = (r_p != HEAD); nxt_wa = r_p[NW-1:0]; nxt_wd = LW'(r_n);
                prv_we = (r_tgt != TAIL); prv_wa = r_tgt[NW-1:0]; prv_wd = LW'(r_n);
            end
            S_U1: begin
                nxt_we = (r_prv_rd != HEAD); nxt_wa = r_prv_rd[NW-1:0];
                nxt_wd = r_nxt_rd;
                prv_we = (r_nxt_rd != TAIL); prv_wa = r_nxt_rd[NW-1:0];
                prv_wd = r_prv_rd;
                fs_we  = (r_top < POOL_C);
            end
            S_WALK: nxt_ra = r_cur[NW-1:0];
            S_ACC: begin
                val_we = (r_op == OP_WRITE_AT);
                val_wa = r_cur[NW-1:0];
            end
            S_FIN: val_ra = r_head_next[NW-1:0];
            S_F1:  val_ra = r_tail_prev[NW-1:0];
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (nxt_we) begin
            m_nxt[nxt_wa] <= nxt_wd;
        end
        r_nxt_rd <= m_nxt[nxt_ra];
    end

    always_ff @(posedge i_clk) begin
        if (prv_we) begin
            m_prv[prv_wa] <= prv_wd;
        end
        r_prv_rd <= m_prv[prv_ra];
    end

    always_ff @(posedge i_clk) begin
        if (val_we) begin
            m_val[val_wa] <= val_wd;
        end
        r_val_rd <= m_val[val_ra];
    end

    // entries below the low-water mark hold stale contents; the sequencer computes them instead
    always_ff @(posedge i_clk) begin
        if (fs_we) begin
            m_fs[fs_wa] <= fs_wd;
        end
        r_fs_rd <= m_fs[fs_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head_next <= TAIL;
            r_tail_prev <= HEAD;
            r_live      <= '0;
            r_top       <= POOL_C;
            r_min_top   <= POOL_C;
            r_count     <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_start) begin
                        r_op     <= i_op;
                        r_val    <= i_value;
                        r_pos    <= i_pos;
                        r_rd     <= '0;
                        r_handle <= '0;
                        r_cur    <= r_head_next;
                        r_i      <= '0;
                        case (i_op)
                            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                                r_tgt <= (i_op == OP_PUSH_FRONT) ? r_head_next : TAIL;
                                if (r_top == '0) begin
                                    r_status <= ST_FULL;
                                    r_state  <= S_FIN;
                                end else begin
                                    r_status <= ST_OK;
                                    r_state  <= S_L0;
                                end
                            end
                            OP_INSERT: begin
                                r_tgt <= LW'(i_pos);
                                if (!(LW'(i_pos) == TAIL || w_pos_live)) begin
                                    r_status <= ST_BAD;
                                    r_state  <= S_FIN;
                                end else if (r_top == '0) begin
                                    r_status <= ST_FULL;
                                    r_state  <= S_FIN;
                                end else begin
                                    r_status <= ST_OK;
                                    r_state  <= S_L0;
                                end
                            end
                            OP_POP_FRONT, OP_POP_BACK: begin
                                r_tgt <= (i_op == OP_POP_FRONT) ? r_head_next : r_tail_prev;
                                r_status <= ST_OK;
                                r_state  <= (r_count != '0) ? S_U0 : S_FIN;
                            end
                            OP_ERASE: begin
                                r_tgt <= LW'(i_pos);
                                if (w_pos_live) begin
                                    r_status <= ST_OK;
                                    r_state  <= S_U0;
                                end else begin
                                    r_status <= ST_BAD;
                                    r_state  <= S_FIN;
                                end
                            end
                            OP_READ_AT, OP_WRITE_AT: begin
                                if (i_pos >= r_count) begin
                                    r_status <= ST_BAD;
                                    r_state  <= S_FIN;
                                end else begin
                                    r_status <= ST_OK;
                                    r_state  <= S_WALK;
                                end
                            end
                            OP_CLEAR: begin
                                r_status    <= ST_OK;
                                r_state     <= S_FIN;
                                r_head_next <= TAIL;
                                r_tail_prev <= HEAD;
                                r_live      <= '0;
                                r_top       <= POOL_C;
                                r_min_top   <= POOL_C;
                                r_count     <= '0;
                            end
                            default: begin
                                r_status <= ST_BAD;
                                r_state  <= S_FIN;
                            end
                        endcase
                    end
                end
                S_L0: begin
                    r_fs_init <= (w_top_m1 < r_min_top);
                    r_fs_val  <= LAST_N - w_top_m1[NW-1:0];
                    r_state   <= S_L1;
                end
                S_L1: begin
                    r_n             <= w_new_n;
                    r_p             <= w_new_p;
                    r_live[w_new_n] <= 1'b1;
                    r_top           <= w_top_m1;
                    if (w_top_m1 < r_min_top) begin
                        r_min_top <= w_top_m1;
                    end
                    r_count <= r_count + PW'(1);
                    if (r_op == OP_INSERT) begin
                        r_handle <= PW'(w_new_n);
                    end
                    r_state <= S_L2;
                end
                S_L2: begin
                    if (r_p == HEAD) begin
                        r_head_next <= LW'(r_n);
                    end
                    if (r_tgt == TAIL) begin
                        r_tail_prev <= LW'(r_n);
                    end
                    r_state <= S_FIN;
                end
                S_U0: r_state <= S_U1;
                S_U1: begin
                    if (r_prv_rd == HEAD) begin
                        r_head_next <= r_nxt_rd;
                    end
                    if (r_nxt_rd == TAIL) begin
                        r_tail_prev <= r_prv_rd;
                    end
                    r_live[r_tgt[NW-1:0]] <= 1'b0;
                    if (r_top < POOL_C) begin
                        r_top <= r_top + PW'(1);
                    end
                    if (r_count != '0) begin
                        r_count <= r_count - PW'(1);
                    end
                    if (r_op == OP_ERASE) begin
                        r_handle <= PW'(r_nxt_rd);
                    end
                    r_state <= S_FIN;
                end
                S_WALK: r_state <= (r_i == r_pos) ? S_ACC : S_WAIT;
                S_WAIT: begin
                    r_cur   <= r_nxt_rd;
                    r_i     <= r_i + PW'(1);
                    r_state <= S_WALK;
                end
                S_ACC: r_state <= (r_op == OP_READ_AT) ? S_RDV : S_FIN;
                S_RDV: begin
                    r_rd    <= r_val_rd;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (r_count == '0) begin
                        r_fr    <= '0;
                        r_bk    <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_F1;
                    end
                end
                S_F1: begin
                    r_fr    <= r_val_rd;
                    r_state <= S_F2;
                end
                S_F2: begin
                    r_bk    <= r_val_rd;
                    r_state <= S_DONE;
                end
                S_DONE: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res_push      = (r_state == S_DONE);
    assign o_status        = r_status;
    assign o_read_value    = r_rd;
    assign o_node_handle   = r_handle;
    assign o_front_value   = r_fr;
    assign o_back_value    = r_bk;
    assign o_element_count = r_count;

endmodule

FILE: rtl/core/linked_list_node_pool_manager_top.sv
// ----------------------------------------------------------------------------
// linked_list_node_pool_manager_top
// doubly linked list over a fixed node pool, request queue in, result queue out
// ----------------------------------------------------------------------------
// requests: one at a time, taken only while the sequencer is idle and the result queue has room
// reset: synchronous active low; list empty, every node free, values kept
module linked_list_node_pool_manager_top #(
    parameter int POOL_NODES = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [3:0]                   i_mode,
    input  logic signed [VALUE_BITS-1:0] i_value,
    input  logic [$clog2(POOL_NODES+1)-1:0] i_position,
    output logic                         empty,
    input  logic                         pop,
    output logic [1:0]                   o_status,
    output logic signed [VALUE_BITS-1:0] o_read_value,
    output logic [$clog2(POOL_NODES+1)-1:0] o_node_handle,
    output logic signed [VALUE_BITS-1:0] o_front_value,
    output logic signed [VALUE_BITS-1:0] o_back_value,
    output logic [$clog2(POOL_NODES+1)-1:0] o_element_count
);
    import llp_pkg::*;

    localparam int PW = $clog2(POOL_NODES + 1);
    localparam int RW = 2 + 3 * VALUE_BITS + 2 * PW;

    logic                  w_avail, w_take, w_out_full, w_res_push;
    logic [3:0]            w_op;
    logic [VALUE_BITS-1:0] w_value;
    logic [PW-1:0]         w_pos;
    logic [1:0]            w_status;
    logic [VALUE_BITS-1:0] w_rd, w_fr, w_bk;
    logic [PW-1:0]         w_handle, w_count;
    logic [RW-1:0]         w_res;

    llp_front #(.VALUE_BITS(VALUE_BITS), .PW(PW)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_mode     (i_mode),
        .i_value    (i_value),
        .i_position (i_position),
        .i_take     (w_take),
        .o_avail    (w_avail),
        .o_op       (w_op),
        .o_value    (w_value),
        .o_pos      (w_pos)
    );

    llp_back #(.POOL_NODES(POOL_NODES), .VALUE_BITS(VALUE_BITS), .PW(PW)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_avail         (w_avail),
        .o_take          (w_take),
        .i_op            (w_op),
        .i_value         (w_value),
        .i_pos           (w_pos),
        .i_out_full      (w_out_full),
        .o_res_push      (w_res_push),
        .o_status        (w_status),
        .o_read_value    (w_rd),
        .o_node_handle   (w_handle),
        .o_front_value   (w_fr),
        .o_back_value    (w_bk),
        .o_element_count (w_count)
    );

    llp_fifo #(.WIDTH(RW)) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .o_full  (w_out_full),
        .i_data  ({w_status, w_rd, w_handle, w_fr, w_bk, w_count}),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (w_res)
    );

    assign {o_status, o_read_value, o_node_handle, o_front_value, o_back_value,
            o_element_count} = w_res;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_element_count <= PW'(POOL_NODES))
        else $error("element count above pool size");

    a_full_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status == ST_FULL) |-> o_element_count == PW'(POOL_NODES))
        else $error("pool full reported with free nodes");

    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> empty)
        else $error("result queue not empty after reset");

endmodule
